@@ sv/cbe_pkg.sv @@
// ----------------------------------------------------------------------------
// cbe_pkg
// Shared types, widths and helpers of the cubic bezier ease solver.
// ----------------------------------------------------------------------------
package cbe_pkg;

    localparam int FRAC_BITS    = 16;
    localparam int IFRAC        = 24;
    localparam int SHIFT        = IFRAC - FRAC_BITS;
    localparam int NEWTON_STEPS = 8;
    localparam int ITER_W       = $clog2(NEWTON_STEPS + 1);

    localparam int PORT_W  = 19;
    localparam int CX_W    = 17;
    localparam int IDX_W   = 2;
    localparam int DW      = 36;   // internal q24 datapath
    localparam int TW      = 28;   // curve parameter t, bounded to [-4,4]
    localparam int MAG_A_W = 32;
    localparam int MAG_B_W = 27;
    localparam int PROD_W  = MAG_A_W + MAG_B_W;
    localparam int DEN_W   = 35;
    localparam int QCAP_SH = 28;   // quotients at or above 2^28 saturate t anyway
    localparam int QW      = QCAP_SH + 1;
    localparam int CNT_W   = $clog2(QCAP_SH + 1);
    localparam int NW      = DEN_W + IFRAC + 1;
    localparam int EPS_Q24 = 16;

    localparam logic [CX_W-1:0]          CX_ONE   = CX_W'(1 << FRAC_BITS);
    localparam logic signed [PORT_W-1:0] PORT_ONE = PORT_W'(1 << FRAC_BITS);
    localparam logic signed [PORT_W-1:0] OUT_MAX  = PORT_W'(131071);
    localparam logic signed [PORT_W-1:0] OUT_MIN  = PORT_W'(-131072);
    localparam logic signed [DW-1:0]     IONE     = DW'(1 << IFRAC);
    localparam logic signed [TW-1:0]     T_ONE    = TW'(1 << IFRAC);
    localparam logic signed [TW-1:0]     T_MAX    = TW'(4 << IFRAC);
    localparam logic signed [TW-1:0]     T_MIN    = -T_MAX;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_MWAIT,
        ST_DIV,
        ST_DWAIT,
        ST_OUT
    } state_t;

    typedef enum logic [1:0] {
        POLY_ERR,
        POLY_DX,
        POLY_Y
    } poly_t;

    typedef enum logic [IDX_W-1:0] {
        REG_X1 = 2'd0,
        REG_Y1 = 2'd1,
        REG_X2 = 2'd2,
        REG_Y2 = 2'd3
    } cfg_reg_t;

    function automatic logic [DEN_W-1:0] mag_of(input logic signed [DW-1:0] v);
        logic signed [DW-1:0] m;
        m = v[DW-1] ? -v : v;
        return m[DEN_W-1:0];
    endfunction

    // q24 to port format, round half away from zero, saturate
    function automatic logic signed [PORT_W-1:0] to_port(input logic signed [DW-1:0] v);
        logic [DEN_W:0]       rm;
        logic [DEN_W-SHIFT:0] rs;
        logic signed [PORT_W-1:0] r;
        rm = (DEN_W+1)'(mag_of(v)) + (DEN_W+1)'(1 << (SHIFT - 1));
        rs = rm[DEN_W:SHIFT];
        if (!v[DW-1] && rs > (DEN_W-SHIFT+1)'(131071))
            r = OUT_MAX;
        else if (v[DW-1] && rs > (DEN_W-SHIFT+1)'(131072))
            r = OUT_MIN;
        else if (v[DW-1])
            r = -PORT_W'(rs);
        else
            r = PORT_W'(rs);
        return r;
    endfunction

endpackage

@@ sv/cubic_bezier_ease_solver_core.sv @@
// ----------------------------------------------------------------------------
// cubic_bezier_ease_solver_core
// Cubic bezier timing curve: newton solve of x(t)=progress, then y(t).
// ----------------------------------------------------------------------------
// Usage:
//   cfg channel writes the control points (index 0..3: x1, y1, x2, y2);
//   cfg_ready is always high; the user must write only while idle (not enforced).
//   in channel takes one progress request (signed q16); out channel returns
//   eased_value (signed q16, saturated) for it.
//   Progress at or below 0 or at or above 1 answers on the cycle after the
//   request. Otherwise each newton step makes up to 5 passes through the
//   shared multiplier and one through the radix-2 divider; up to 8 steps run,
//   then the final y evaluation, fewer when the iteration converges early.
//   One request at a time: in_ready is low from the request until its result
//   has been taken. A stalled receiver holds the result in the output
//   register, out_valid stays high and no new request is taken.
//   Reset returns the control points to a linear curve (0,0), (1,1) and
//   empties the block.
// ----------------------------------------------------------------------------
module cubic_bezier_ease_solver_core import cbe_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  logic [IDX_W-1:0]         cfg_index,
    input  logic [PORT_W-1:0]        cfg_data,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic signed [PORT_W-1:0] progress,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic signed [PORT_W-1:0] eased_value
);

    state_t state_reg, state_next;
    poly_t  poly_reg, poly_next;
    logic [1:0]        term_reg, term_next;
    logic [ITER_W-1:0] iter_reg, iter_next;

    logic [CX_W-1:0]          x1_reg, x2_reg;
    logic signed [PORT_W-1:0] y1_reg, y2_reg;

    logic signed [DW-1:0] ax_reg, bx_reg, cx_reg, ay_reg, by_reg, cy_reg;
    logic signed [DW-1:0] ax_next, bx_next, cx_next, ay_next, by_next, cy_next;
    logic signed [DW-1:0] target_reg, target_next;
    logic signed [DW-1:0] acc_reg, acc_next;
    logic signed [DW-1:0] err_reg, err_next;
    logic signed [DW-1:0] dx_reg, dx_next;
    logic signed [TW-1:0] t_reg, t_next;
    logic signed [PORT_W-1:0] res_reg, res_next;

    logic accept;
    logic p_low, p_high;
    logic mul_start, mul_done, div_start, div_done;
    logic signed [DW-1:0] mul_prod;
    logic [QW-1:0]        div_quo;

    logic signed [DW-1:0] addend, sum;
    logic last_term, sum_small, last_iter;
    logic [CX_W-1:0]      x1c, x2c;
    logic signed [DW-1:0] x1q, x2q, y1q, y2q, dxq, dyq;
    logic signed [TW+1:0] t_ext, q_ext, t_wide;
    logic signed [TW-1:0] t_upd;

    function automatic logic signed [TW-1:0] clamp01(input logic signed [TW-1:0] v);
        logic signed [TW-1:0] r;
        if (v[TW-1])
            r = '0;
        else if (v > T_ONE)
            r = T_ONE;
        else
            r = v;
        return r;
    endfunction

    // ---------------- configuration ----------------
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x1_reg <= '0;
            y1_reg <= '0;
            x2_reg <= CX_ONE;
            y2_reg <= PORT_ONE;
        end
        else if (cfg_valid)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_X1:  x1_reg <= cfg_data[CX_W-1:0];
                REG_Y1:  y1_reg <= $signed(cfg_data);
                REG_X2:  x2_reg <= cfg_data[CX_W-1:0];
                REG_Y2:  y2_reg <= $signed(cfg_data);
                default: x1_reg <= x1_reg;
            endcase
        end
    end

    // ---------------- shared units ----------------
    cbe_mul u_mul
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mul_start),
        .a     (acc_reg),
        .b     (t_reg),
        .done  (mul_done),
        .prod  (mul_prod)
    );

    cbe_div u_div
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (div_start),
        .num_mag (mag_of(err_reg)),
        .den_mag (mag_of(dx_reg)),
        .done    (div_done),
        .quo     (div_quo)
    );

    // ---------------- datapath terms ----------------
    always_comb
    begin
        accept = in_valid && in_ready;
        p_low  = progress[PORT_W-1] || (progress == '0);
        p_high = !progress[PORT_W-1] && (progress >= PORT_ONE);

        x1c = (x1_reg > CX_ONE) ? CX_ONE : x1_reg;
        x2c = (x2_reg > CX_ONE) ? CX_ONE : x2_reg;
        x1q = $signed(DW'(x1c)) <<< SHIFT;
        x2q = $signed(DW'(x2c)) <<< SHIFT;
        y1q = DW'(y1_reg) <<< SHIFT;
        y2q = DW'(y2_reg) <<< SHIFT;
        dxq = x2q - x1q;
        dyq = y2q - y1q;
        cx_next = x1q + (x1q <<< 1);
        bx_next = dxq + (dxq <<< 1) - cx_next;
        ax_next = IONE - cx_next - bx_next;
        cy_next = y1q + (y1q <<< 1);
        by_next = dyq + (dyq <<< 1) - cy_next;
        ay_next = IONE - cy_next - by_next;
        target_next = DW'(progress) <<< SHIFT;

        // horner addend for the current multiply
        addend = '0;
        case (term_reg)
            2'd0:
                case (poly_reg)
                    POLY_ERR: addend = bx_reg;
                    POLY_DX:  addend = bx_reg <<< 1;
                    default:  addend = by_reg;
                endcase
            2'd1:
                addend = (poly_reg == POLY_Y) ? cy_reg : cx_reg;
            default:
                addend = (poly_reg == POLY_ERR) ? -target_reg : '0;
        endcase
        sum       = mul_prod + addend;
        last_term = (poly_reg == POLY_DX) ? (term_reg == 2'd1) : (term_reg == 2'd2);
        sum_small = (mag_of(sum) < DEN_W'(EPS_Q24));

        t_ext  = {{2{t_reg[TW-1]}}, t_reg};
        q_ext  = {1'b0, div_quo};
        t_wide = (err_reg[DW-1] ^ dx_reg[DW-1]) ? t_ext + q_ext : t_ext - q_ext;
        if (t_wide > T_MAX)
            t_upd = T_MAX;
        else if (t_wide < T_MIN)
            t_upd = T_MIN;
        else
            t_upd = t_wide[TW-1:0];
        last_iter = (iter_reg == ITER_W'(NEWTON_STEPS - 1));
    end

    // ---------------- next state ----------------
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
                if (accept)
                    state_next = (p_low || p_high) ? ST_OUT : ST_MUL;
            ST_MUL:
                state_next = ST_MWAIT;
            ST_MWAIT:
                if (mul_done)
                begin
                    if (!last_term)
                        state_next = ST_MUL;
                    else if (poly_reg == POLY_Y)
                        state_next = ST_OUT;
                    else if (poly_reg == POLY_DX && !sum_small)
                        state_next = ST_DIV;
                    else
                        state_next = ST_MUL;
                end
            ST_DIV:
                state_next = ST_DWAIT;
            ST_DWAIT:
                if (div_done)
                    state_next = ST_MUL;
            ST_OUT:
                if (out_ready)
                    state_next = ST_IDLE;
            default:
                state_next = ST_IDLE;
        endcase
    end

    // ---------------- state outputs ----------------
    always_comb
    begin
        in_ready  = (state_reg == ST_IDLE);
        out_valid = (state_reg == ST_OUT);
        mul_start = (state_reg == ST_MUL);
        div_start = (state_reg == ST_DIV);
    end

    // ---------------- register updates ----------------
    always_comb
    begin
        poly_next = poly_reg;
        term_next = term_reg;
        iter_next = iter_reg;
        acc_next  = acc_reg;
        err_next  = err_reg;
        dx_next   = dx_reg;
        t_next    = t_reg;
        res_next  = res_reg;
        case (state_reg)
            ST_IDLE:
                if (accept)
                begin
                    res_next  = p_high ? PORT_ONE : '0;
                    poly_next = POLY_ERR;
                    term_next = 2'd0;
                    iter_next = '0;
                    acc_next  = ax_next;
                    t_next    = TW'(target_next);
                end
            ST_MWAIT:
                if (mul_done)
                begin
                    acc_next  = sum;
                    term_next = term_reg + 2'd1;
                    if (last_term)
                    begin
                        case (poly_reg)
                            POLY_ERR:
                                if (sum_small)
                                begin
                                    // converged: evaluate y at the clamped t
                                    t_next    = clamp01(t_reg);
                                    acc_next  = ay_reg;
                                    poly_next = POLY_Y;
                                    term_next = 2'd0;
                                end
                                else
                                begin
                                    err_next  = sum;
                                    acc_next  = ax_reg + (ax_reg <<< 1);
                                    poly_next = POLY_DX;
                                    term_next = 2'd0;
                                end
                            POLY_DX:
                                if (sum_small)
                                begin
                                    // flat slope: stop here
                                    t_next    = clamp01(t_reg);
                                    acc_next  = ay_reg;
                                    poly_next = POLY_Y;
                                    term_next = 2'd0;
                                end
                                else
                                    dx_next = sum;
                            default:
                                res_next = to_port(sum);
                        endcase
                    end
                end
            ST_DWAIT:
                if (div_done)
                begin
                    iter_next = iter_reg + ITER_W'(1);
                    term_next = 2'd0;
                    if (last_iter)
                    begin
                        t_next    = clamp01(t_upd);
                        acc_next  = ay_reg;
                        poly_next = POLY_Y;
                    end
                    else
                    begin
                        t_next    = t_upd;
                        acc_next  = ax_reg;
                        poly_next = POLY_ERR;
                    end
                end
            default:
                acc_next = acc_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            poly_reg  <= POLY_ERR;
            term_reg  <= 2'd0;
            iter_reg  <= '0;
            t_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            poly_reg  <= poly_next;
            term_reg  <= term_next;
            iter_reg  <= iter_next;
            t_reg     <= t_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        err_reg <= err_next;
        dx_reg  <= dx_next;
        res_reg <= res_next;
        if (accept)
        begin
            ax_reg     <= ax_next;
            bx_reg     <= bx_next;
            cx_reg     <= cx_next;
            ay_reg     <= ay_next;
            by_reg     <= by_next;
            cy_reg     <= cy_next;
            target_reg <= target_next;
        end
    end

    assign eased_value = res_reg;

    // ---------------- assertions ----------------
    a_one_request: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !in_ready)
        else $error("request taken while a result is pending");

    a_low_end: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && progress[PORT_W-1]) |=> (out_valid && eased_value == '0))
        else $error("negative progress did not answer zero");

    a_iter_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_IDLE) |-> (iter_reg <= ITER_W'(NEWTON_STEPS)))
        else $error("newton step count overran");

    a_t_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_IDLE) |-> (t_reg <= T_MAX && t_reg >= T_MIN))
        else $error("curve parameter out of range");

endmodule

@@ sv/cbe_mul.sv @@
// ----------------------------------------------------------------------------
// cbe_mul
// Shared q24 multiplier, two stages: magnitude product, then rounding.
// ----------------------------------------------------------------------------
module cbe_mul import cbe_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic signed [DW-1:0] a,
    input  logic signed [TW-1:0] b,
    output logic                 done,
    output logic signed [DW-1:0] prod
);

    logic [MAG_A_W-1:0] mag_a;
    logic [MAG_B_W-1:0] mag_b;
    logic signed [DW-1:0] abs_a;
    logic signed [TW-1:0] abs_b;

    logic [PROD_W-1:0]    prod_reg;
    logic                 neg_reg;
    logic                 v1_reg;
    logic                 done_reg;
    logic signed [DW-1:0] res_reg;
    logic signed [DW-1:0] res_next;
    logic [PROD_W:0]      rsum;
    logic [DW-1:0]        rmag;

    always_comb
    begin
        abs_a = a[DW-1] ? -a : a;
        abs_b = b[TW-1] ? -b : b;
        mag_a = abs_a[MAG_A_W-1:0];
        mag_b = abs_b[MAG_B_W-1:0];
    end

    always_comb
    begin
        rsum = {1'b0, prod_reg} + ((PROD_W+1)'(1) << (IFRAC - 1));
        rmag = DW'(rsum[PROD_W:IFRAC]);
        res_next = neg_reg ? -$signed(rmag) : $signed(rmag);
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= mag_a * mag_b;
        neg_reg  <= a[DW-1] ^ b[TW-1];
        res_reg  <= res_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg   <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            v1_reg   <= start;
            done_reg <= v1_reg;
        end
    end

    assign done = done_reg;
    assign prod = res_reg;

endmodule

@@ sv/cbe_div.sv @@
// ----------------------------------------------------------------------------
// cbe_div
// Radix-2 restoring divider for the newton correction, rounded, capped at 2^28.
// ----------------------------------------------------------------------------
module cbe_div import cbe_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [DEN_W-1:0] num_mag,
    input  logic [DEN_W-1:0] den_mag,
    output logic             done,
    output logic [QW-1:0]    quo
);

    logic [NW-1:0]      n_full;
    logic [DEN_W-1:0]   n_hi;
    logic               cap;

    logic               busy_reg;
    logic               done_reg;
    logic [CNT_W-1:0]   cnt_reg;
    logic [DEN_W-1:0]   rem_reg;
    logic [DEN_W-1:0]   den_reg;
    logic [QCAP_SH-1:0] low_reg;
    logic [QW-1:0]      quo_reg;

    logic [DEN_W:0]     sh;
    logic               ge;
    logic [DEN_W-1:0]   rem_next;
    logic [QCAP_SH-1:0] low_next;

    always_comb
    begin
        n_full = {1'b0, num_mag, IFRAC'(0)} + NW'(den_mag >> 1);
        n_hi   = DEN_W'(n_full[NW-1:QCAP_SH]);
        cap    = (n_hi >= den_mag);
    end

    always_comb
    begin
        sh       = {rem_reg, low_reg[QCAP_SH-1]};
        ge       = (sh >= {1'b0, den_reg});
        rem_next = ge ? DEN_W'(sh - {1'b0, den_reg}) : DEN_W'(sh);
        low_next = {low_reg[QCAP_SH-2:0], ge};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                if (cap)
                    done_reg <= 1'b1;
                else
                begin
                    busy_reg <= 1'b1;
                    cnt_reg  <= CNT_W'(QCAP_SH);
                end
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - CNT_W'(1);
                if (cnt_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            den_reg <= den_mag;
            rem_reg <= n_hi;
            low_reg <= n_full[QCAP_SH-1:0];
            if (cap)
                quo_reg <= QW'(1) << QCAP_SH;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            low_reg <= low_next;
            if (cnt_reg == CNT_W'(1))
                quo_reg <= {1'b0, low_next};
        end
    end

    assign done = done_reg;
    assign quo  = quo_reg;

endmodule
